[sv/bsa_pkg.sv]
// Package for the bitmap slot allocator: sizes, payload structs, status codes,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
`default_nettype none

package bsa_pkg;

  // Number of slots managed by the allocator
  localparam int NUM_SLOTS = 8192;

  // Bitmap memory organization: 64 occupancy bits per word
  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  // Bits of the last word that lie beyond the last slot read as occupied
  localparam int LAST_BITS = NUM_SLOTS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] PAD_MASK =
      ~((({{(WORD_W-1){1'b0}}, 1'b1}) << LAST_BITS) - 1'b1);

  // Field widths of the payload
  localparam int REQ_SLOT_W = 14;
  localparam int GRANT_W    = 13;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e               opcode;
    logic [REQ_SLOT_W-1:0] slot_to_free;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [GRANT_W-1:0] granted_slot;
  } rsp_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_DECODE,
    CS_FREE_CHK,
    CS_ALLOC_CHK
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    clr_step;
    logic    accept;
    logic    rd_free;
    logic    rd_first;
    logic    rd_next;
    logic    commit_free;
    logic    commit_alloc;
    logic    res_load;
    status_e res_status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic    clr_last;
    opcode_e req_op;
    logic    range_bad;
    logic    full;
    logic    bit_set;
    logic    found;
    logic    out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

[sv/bsa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/bsa_ctrl.sv]
// Controller state machine of the bitmap slot allocator: clearing pass,
// request decode, free check and word-by-word allocate scan. Uses bsa_pkg.
`default_nettype none

module bsa_ctrl
  import bsa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t stat_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res_status = ST_OK;
    in_stall_o = 1'b1;

    unique case (state_q)
      CS_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = CS_IDLE;
        end
      end

      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = CS_DECODE;
        end
      end

      CS_DECODE: begin
        if (stat_i.req_op == OP_FREE) begin
          if (stat_i.range_bad) begin
            // Report a slot out of range once the output is free
            if (!stat_i.out_busy) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_RANGE;
              state_d          = CS_IDLE;
            end
          end else begin
            cmd_o.rd_free = 1'b1;
            state_d       = CS_FREE_CHK;
          end
        end else begin
          if (stat_i.full) begin
            if (!stat_i.out_busy) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = ST_FULL;
              state_d          = CS_IDLE;
            end
          end else begin
            cmd_o.rd_first = 1'b1;
            state_d        = CS_ALLOC_CHK;
          end
        end
      end

      CS_FREE_CHK: begin
        // Hold the read word until the output can take the result
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = CS_IDLE;
          if (stat_i.bit_set) begin
            cmd_o.commit_free = 1'b1;
            cmd_o.res_status  = ST_OK;
          end else begin
            cmd_o.res_status  = ST_DOUBLE;
          end
        end
      end

      CS_ALLOC_CHK: begin
        if (stat_i.found) begin
          if (!stat_i.out_busy) begin
            cmd_o.commit_alloc = 1'b1;
            cmd_o.res_load     = 1'b1;
            cmd_o.res_status   = ST_OK;
            state_d            = CS_IDLE;
          end
        end else begin
          // Advance to the next word of the scan
          cmd_o.rd_next = 1'b1;
        end
      end

      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/bsa_datapath.sv]
// Datapath of the bitmap slot allocator: bitmap RAM, search hint, fill count,
// scan pointer and output register. Uses bsa_pkg and bsa_ram.
`default_nettype none

module bsa_datapath
  import bsa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire req_t      in_req_i,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output rsp_t           out_rsp_o,
  input  wire ctrl_cmd_t cmd_i,
  output dp_status_t     stat_o
);

  // Index of the lowest set bit of a word
  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  req_t              req_q;
  logic [SLOT_W-1:0] hint_q;
  logic [CNT_W-1:0]  count_q;
  logic [ADDR_W-1:0] scan_word_q;
  logic              first_q;
  logic [ADDR_W-1:0] clr_q;
  logic              out_valid_q;
  rsp_t              rsp_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [SLOT_W-1:0] free_slot;
  logic [ADDR_W-1:0] free_word;
  logic [BIT_W-1:0]  free_bit;
  logic [ADDR_W-1:0] hint_word;
  logic [BIT_W-1:0]  hint_bit;
  logic [ADDR_W-1:0] next_word;
  logic [WORD_W-1:0] taken_vec;
  logic [WORD_W-1:0] open_vec;
  logic [BIT_W-1:0]  found_bit;
  logic [SLOT_W-1:0] found_slot;
  logic [SLOT_W-1:0] next_hint;
  logic              out_busy;

  // Split request and hint into word and bit
  assign free_slot = SLOT_W'(32'(req_q.slot_to_free));
  assign free_word = ADDR_W'(32'(free_slot) >> BIT_W);
  assign free_bit  = BIT_W'(32'(free_slot));
  assign hint_word = ADDR_W'(32'(hint_q) >> BIT_W);
  assign hint_bit  = BIT_W'(32'(hint_q));
  assign next_word = (scan_word_q == ADDR_W'(NUM_WORDS - 1)) ? '0 : scan_word_q + 1'b1;

  // Mask padding bits and, in the hint word on the first pass, bits below the hint
  always_comb begin
    taken_vec = ram_rdata;
    if (scan_word_q == ADDR_W'(NUM_WORDS - 1)) begin
      taken_vec = taken_vec | PAD_MASK;
    end
    if (first_q) begin
      taken_vec = taken_vec | ((({{(WORD_W-1){1'b0}}, 1'b1}) << hint_bit) - 1'b1);
    end
  end

  assign open_vec   = ~taken_vec;
  assign found_bit  = lowest_one(open_vec);
  assign found_slot = SLOT_W'((32'(scan_word_q) << BIT_W) | 32'(found_bit));
  assign next_hint  = (32'(found_slot) + 1 == NUM_SLOTS) ? '0 : found_slot + 1'b1;
  assign out_busy   = out_valid_q && out_stall_i;

  // Status toward the controller
  always_comb begin
    stat_o.clr_last  = (clr_q == ADDR_W'(NUM_WORDS - 1));
    stat_o.req_op    = req_q.opcode;
    stat_o.range_bad = (32'(req_q.slot_to_free) >= NUM_SLOTS);
    stat_o.full      = (count_q == CNT_W'(NUM_SLOTS));
    stat_o.bit_set   = ram_rdata[free_bit];
    stat_o.found     = |open_vec;
    stat_o.out_busy  = out_busy;
  end

  // RAM write port: clearing pass, set on allocate, clear on free
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_word_q;
    ram_wdata = ram_rdata;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.commit_alloc) begin
      ram_we    = 1'b1;
      ram_waddr = scan_word_q;
      ram_wdata = ram_rdata | (WORD_W'(1) << found_bit);
    end else if (cmd_i.commit_free) begin
      ram_we    = 1'b1;
      ram_waddr = free_word;
      ram_wdata = ram_rdata & ~(WORD_W'(1) << free_bit);
    end
  end

  // RAM read port
  always_comb begin
    ram_re    = cmd_i.rd_free || cmd_i.rd_first || cmd_i.rd_next;
    ram_raddr = next_word;
    if (cmd_i.rd_free) begin
      ram_raddr = free_word;
    end else if (cmd_i.rd_first) begin
      ram_raddr = hint_word;
    end
  end

  bsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_req_i;
    end
  end

  // Advance the scan pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_first) begin
      scan_word_q <= hint_word;
      first_q     <= 1'b1;
    end else if (cmd_i.rd_next) begin
      scan_word_q <= next_word;
      first_q     <= 1'b0;
    end
  end

  // Control state: clearing counter, hint, fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      hint_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.commit_alloc) begin
        hint_q  <= next_hint;
        count_q <= count_q + 1'b1;
      end else if (cmd_i.commit_free) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Output register: load a result, drop valid after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      rsp_q.status       <= cmd_i.res_status;
      rsp_q.granted_slot <= cmd_i.commit_alloc ? GRANT_W'(32'(found_slot)) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Fill count never passes the number of slots
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= NUM_SLOTS)
    else $error("fill count above slot count");

  // Hint always names a real slot
  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hint_q) < NUM_SLOTS)
    else $error("search hint out of range");

  // A grant needs a free bit and a free output register
  a_grant_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_alloc |-> (stat_o.found && !out_busy && cmd_i.res_load))
    else $error("grant without free bit or output space");

  // A grant raises the fill count by one
  a_grant_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_alloc |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count not advanced on grant");

  // Allocate never reaches the RAM while every slot is taken
  a_no_scan_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_first |-> !stat_o.full)
    else $error("scan started on a full bitmap");

endmodule

`default_nettype wire

[sv/bitmap_slot_allocator.sv]
// Top level of the bitmap slot allocator: joins the controller and datapath.
// Uses bsa_pkg, bsa_ctrl and bsa_datapath.
`default_nettype none

// Next-fit slot allocator over an occupancy bitmap held in a RAM of 64-bit
// words (NUM_SLOTS/64 words). After reset the block runs a clearing pass over
// all NUM_WORDS words with in_stall_o high. One request is worked at a time.
// A free, or a rejected request (out of range, or full, which a fill count
// detects at once), passes through decode, and a free also through a check of
// the read word, before its result is loaded, waiting while the output is busy.
// An allocate reads one bitmap word per cycle from the hint word on, wrapping
// round, until it finds a free bit; the RAM read port sets that pace.
// The result sits in an output register, so a new request is taken while the
// previous result still waits for its transfer.
module bitmap_slot_allocator
  import bsa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  bsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bsa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

`default_nettype wire
